// ----- rtl/cmr_pkg.sv -----
package cmr_pkg;

	// defaults for the top-level parameters
	localparam int MAX_CITIES_DEF = 64;
	localparam int COST_BITS_DEF  = 16;

	// register map, indexed by paddr[2]
	localparam logic REG_CITY_COUNT = 1'b0;

	localparam logic [6:0]  CITY_RESET = 7'd64;
	localparam logic [22:0] SUM_LIMIT  = 23'h7FFFFF;
	localparam logic [16:0] PEN_LIMIT  = 17'h1FFFF;

	// back-end sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RMIN,
		ST_RSUB,
		ST_CMIN,
		ST_CSUB,
		ST_PMIN,
		ST_PSCAN,
		ST_DONE
	} state_t;

endpackage

// ----- rtl/cmr_ram.sv -----
module cmr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/cmr_front.sv -----
module cmr_front import cmr_pkg::*; #(
	parameter int MAX_CITIES = MAX_CITIES_DEF,
	parameter int COST_BITS  = COST_BITS_DEF,
	localparam int RW = $clog2(MAX_CITIES),
	localparam int NW = $clog2(MAX_CITIES + 1),
	localparam int WW = COST_BITS + 2 * RW + 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [NW-1:0] n,
	input  logic          cfg_clr,
	input  logic          push,
	output logic          full,
	input  logic [15:0]   entry_cost,
	input  logic          entry_blocked,
	output logic          q_avail,
	output logic [WW-1:0] q_word,
	input  logic          q_take
);

	localparam int QD = 4;
	localparam int QW = 2;

	logic [RW-1:0]  row_q, col_q;
	logic [QW-1:0]  wp_q, rp_q;
	logic [QW:0]    cnt_q;
	logic [WW-1:0]  buf_q [QD];
	logic           acc, take, col_last, row_last;
	logic [31:0]    cost_ext;
	logic [WW-1:0]  word_in;

	assign acc      = push && !full;
	assign take     = q_take && q_avail;
	assign full     = (cnt_q == (QW+1)'(QD));
	assign q_avail  = (cnt_q != '0);
	assign q_word   = buf_q[rp_q];
	assign cost_ext = {16'b0, entry_cost};
	assign col_last = (NW'(col_q) == n - NW'(1));
	assign row_last = (NW'(row_q) == n - NW'(1));
	assign word_in  = {row_last && col_last, row_q, col_q, entry_blocked,
		cost_ext[COST_BITS-1:0]};

	// load position, row-major
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_clr) begin
			row_q <= '0;
			col_q <= '0;
		end else if (acc) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + RW'(1);
			end
		end
	end

	// word queue to the back end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (acc) wp_q <= wp_q + QW'(1);
			if (take) rp_q <= rp_q + QW'(1);
			if (acc && !take) cnt_q <= cnt_q + (QW+1)'(1);
			else if (take && !acc) cnt_q <= cnt_q - (QW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) buf_q[wp_q] <= word_in;
	end

endmodule

// ----- rtl/cmr_back.sv -----
module cmr_back import cmr_pkg::*; #(
	parameter int MAX_CITIES = MAX_CITIES_DEF,
	parameter int COST_BITS  = COST_BITS_DEF,
	localparam int RW = $clog2(MAX_CITIES),
	localparam int NW = $clog2(MAX_CITIES + 1),
	localparam int AW = $clog2(MAX_CITIES * MAX_CITIES),
	localparam int WW = COST_BITS + 2 * RW + 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [NW-1:0] n,
	input  logic          q_avail,
	input  logic [WW-1:0] q_word,
	output logic          q_take,
	input  logic          pop,
	output logic          empty,
	output logic [22:0]   reduction_total,
	output logic          edge_found,
	output logic [5:0]    best_row,
	output logic [5:0]    best_col,
	output logic [16:0]   best_penalty
);

	localparam int CB = COST_BITS;

	function automatic logic [AW-1:0] mat_addr(input logic [RW-1:0] r,
		input logic [RW-1:0] c);
		return AW'(r) * AW'(MAX_CITIES) + AW'(c);
	endfunction

	state_t state_q, state_d;
	logic [RW-1:0] a_q, a_d;
	logic [NW-1:0] k_q, k_d;
	logic [RW-1:0] k_rw, rk_s1;
	logic [AW-1:0] ra_s1, rd_addr, waddr;
	logic rv_s1, issue, is_col, scan_end, line_last, we;
	logic [CB:0] rdat, wdata;
	logic [CB-1:0] d_cost;
	logic d_blk;

	// queued word fields
	logic [CB-1:0] w_cost;
	logic w_blk, w_last;
	logic [RW-1:0] w_row, w_col;

	// running line statistics: two smallest, position of smallest, count
	logic [CB-1:0] m1_q, m2_q, m1_n, m2_n;
	logic [RW-1:0] arg_q, arg_n;
	logic [1:0] cnt_q, cnt_n;
	logic need;

	// column stats memory: {second minus first, position of smallest}
	logic [CB+RW-1:0] cs_wdata, cs_rdata;
	logic [CB-1:0] c_diff;
	logic [RW-1:0] c_arg;

	// penalty evaluation
	logic [CB-1:0] rowv, colv;
	logic [31:0] pen_ext;
	logic [16:0] pen;
	logic pen_chk;

	logic [22:0] sum_q;
	logic [31:0] sum_ext;
	logic found_q;
	logic [RW-1:0] br_q, bc_q;
	logic [16:0] bp_q;
	logic res_v_q;

	// strobes
	logic st_clr, st_upd, sum_add, cs_we, res_load, start;

	assign w_cost = q_word[CB-1:0];
	assign w_blk  = q_word[CB];
	assign w_col  = q_word[CB+RW:CB+1];
	assign w_row  = q_word[CB+2*RW:CB+RW+1];
	assign w_last = q_word[WW-1];

	assign k_rw      = k_q[RW-1:0];
	assign issue     = (state_q != ST_IDLE) && (state_q != ST_DONE) && (k_q < n);
	assign is_col    = (state_q == ST_CMIN) || (state_q == ST_CSUB);
	assign rd_addr   = is_col ? mat_addr(k_rw, a_q) : mat_addr(a_q, k_rw);
	assign scan_end  = (k_q == n);
	assign line_last = (NW'(a_q) == n - NW'(1));
	assign d_cost    = rdat[CB-1:0];
	assign d_blk     = rdat[CB];

	// matrix write: load from queue or subtract line minimum
	always_comb begin
		if (state_q == ST_IDLE) begin
			we    = q_avail;
			waddr = mat_addr(w_row, w_col);
			wdata = {w_blk, w_cost};
		end else begin
			we    = ((state_q == ST_RSUB) || (state_q == ST_CSUB)) && rv_s1 && !d_blk;
			waddr = ra_s1;
			wdata = {1'b0, d_cost - m1_q};
		end
	end

	cmr_ram #(.WIDTH(CB + 1), .DEPTH(MAX_CITIES * MAX_CITIES)) u_mat (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (rd_addr),
		.rdata (rdat)
	);

	assign cs_wdata = {(cnt_n == 2'd2) ? m2_n - m1_n : CB'(0), arg_n};

	cmr_ram #(.WIDTH(CB + RW), .DEPTH(MAX_CITIES)) u_cstat (
		.clk   (clk),
		.we    (cs_we),
		.waddr (a_q),
		.wdata (cs_wdata),
		.raddr (k_rw),
		.rdata (cs_rdata)
	);

	assign c_diff = cs_rdata[CB+RW-1:RW];
	assign c_arg  = cs_rdata[RW-1:0];

	// statistics update with the word just read
	always_comb begin
		m1_n  = m1_q;
		m2_n  = m2_q;
		arg_n = arg_q;
		cnt_n = cnt_q;
		if (rv_s1 && !d_blk) begin
			if (cnt_q == 2'd0 || d_cost < m1_q) begin
				m2_n  = m1_q;
				m1_n  = d_cost;
				arg_n = rk_s1;
			end else if (cnt_q == 2'd1 || d_cost < m2_q) begin
				m2_n = d_cost;
			end
			if (cnt_q != 2'd2) cnt_n = cnt_q + 2'd1;
		end
	end

	assign need = (cnt_n != 2'd0) && (m1_n != '0);

	// penalty of the zero at (a_q, rk_s1)
	always_comb begin
		if (arg_q == rk_s1) rowv = (cnt_q == 2'd2) ? m2_q : '0;
		else rowv = m1_q;
		colv = (c_arg == a_q) ? c_diff : '0;
	end
	assign pen_ext = 32'(rowv) + 32'(colv);
	assign pen     = (pen_ext > 32'(PEN_LIMIT)) ? PEN_LIMIT : pen_ext[16:0];
	assign pen_chk = (state_q == ST_PSCAN) && rv_s1 && !d_blk && (d_cost == '0);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			a_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			a_q     <= a_d;
			k_q     <= k_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		a_d      = a_q;
		k_d      = scan_end ? '0 : k_q + NW'(1);
		st_clr   = 1'b0;
		st_upd   = 1'b0;
		sum_add  = 1'b0;
		cs_we    = 1'b0;
		res_load = 1'b0;
		start    = 1'b0;
		q_take   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				k_d    = '0;
				q_take = q_avail;
				if (q_avail && w_last) begin
					state_d = ST_RMIN;
					a_d     = '0;
					st_clr  = 1'b1;
					start   = 1'b1;
				end
			end
			ST_RMIN, ST_RSUB: begin
				st_upd = (state_q == ST_RMIN);
				if (scan_end) begin
					if (state_q == ST_RMIN && need) begin
						sum_add = 1'b1;
						state_d = ST_RSUB;
					end else begin
						st_clr  = 1'b1;
						state_d = line_last ? ST_CMIN : ST_RMIN;
						a_d     = line_last ? '0 : a_q + RW'(1);
					end
				end
			end
			ST_CMIN, ST_CSUB: begin
				st_upd = (state_q == ST_CMIN);
				if (scan_end) begin
					cs_we = (state_q == ST_CMIN);
					if (state_q == ST_CMIN && need) begin
						sum_add = 1'b1;
						state_d = ST_CSUB;
					end else begin
						st_clr  = 1'b1;
						state_d = line_last ? ST_PMIN : ST_CMIN;
						a_d     = line_last ? '0 : a_q + RW'(1);
					end
				end
			end
			ST_PMIN: begin
				st_upd = 1'b1;
				if (scan_end) state_d = ST_PSCAN;
			end
			ST_PSCAN: begin
				if (scan_end) begin
					st_clr  = 1'b1;
					state_d = line_last ? ST_DONE : ST_PMIN;
					a_d     = line_last ? '0 : a_q + RW'(1);
				end
			end
			ST_DONE: begin
				k_d = '0;
				if (!res_v_q) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// read pipeline tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rv_s1 <= 1'b0;
		else rv_s1 <= issue;
	end

	always_ff @(posedge clk) begin
		rk_s1 <= k_rw;
		ra_s1 <= rd_addr;
	end

	// line statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (st_clr) begin
			cnt_q <= '0;
		end else if (st_upd) begin
			cnt_q <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		if (st_upd) begin
			m1_q  <= m1_n;
			m2_q  <= m2_n;
			arg_q <= arg_n;
		end
	end

	// lower bound and best zero
	assign sum_ext = 32'(sum_q) + 32'(m1_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			found_q <= 1'b0;
		end else if (start) begin
			sum_q   <= '0;
			found_q <= 1'b0;
		end else begin
			if (sum_add) sum_q <= (sum_ext > 32'(SUM_LIMIT)) ? SUM_LIMIT : sum_ext[22:0];
			if (pen_chk && (!found_q || pen > bp_q)) found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			br_q <= '0;
			bc_q <= '0;
			bp_q <= '0;
		end else if (pen_chk && (!found_q || pen > bp_q)) begin
			br_q <= a_q;
			bc_q <= rk_s1;
			bp_q <= pen;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (res_load) begin
			res_v_q <= 1'b1;
		end else if (pop) begin
			res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			reduction_total <= sum_q;
			edge_found      <= found_q;
			best_row        <= 6'(32'(br_q));
			best_col        <= 6'(32'(bc_q));
			best_penalty    <= bp_q;
		end
	end

	assign empty = !res_v_q;

endmodule

// ----- rtl/cost_matrix_reduce_and_pick_edge_top.sv -----
// Channel  | Handshake             | Word
// ---------+-----------------------+------------------------------------------
// entry    | push / full           | entry_cost, entry_blocked
// result   | empty / pop           | reduction_total, edge_found, best_row,
//          |                       | best_col, best_penalty
// config   | psel/penable/pwrite   | city_count at byte 0
//
// Loading takes one entry per cycle while full is low; a four-word queue lets
// the loader place up to four entries while the back end works on the previous matrix.
// After the last entry the back end makes passes over the single-read matrix
// memory: a minimum pass per row, plus a subtract pass where that minimum is
// nonzero, then the same per column, then a minimum pass and a penalty scan per row.
// Reset clears control state only; the matrix memory is not cleared.
// A result waits in an output register; the next matrix may load meanwhile.
module cost_matrix_reduce_and_pick_edge_top import cmr_pkg::*; #(
	parameter int MAX_CITIES = MAX_CITIES_DEF,
	parameter int COST_BITS  = COST_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        push,
	output logic        full,
	input  logic [15:0] entry_cost,
	input  logic        entry_blocked,
	output logic        empty,
	input  logic        pop,
	output logic [22:0] reduction_total,
	output logic        edge_found,
	output logic [5:0]  best_row,
	output logic [5:0]  best_col,
	output logic [16:0] best_penalty
);

	localparam int NW = $clog2(MAX_CITIES + 1);
	localparam int RW = $clog2(MAX_CITIES);
	localparam int WW = COST_BITS + 2 * RW + 2;

	logic [6:0]    city_count_q;
	logic [NW-1:0] n_eff;
	logic          cfg_wr;
	logic          q_avail, q_take;
	logic [WW-1:0] q_word;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CITY_COUNT);
	assign prdata = (paddr[2] == REG_CITY_COUNT) ? {25'b0, city_count_q} : 32'b0;

	// city count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) city_count_q <= CITY_RESET;
		else if (cfg_wr) city_count_q <= pwdata[6:0];
	end

	// clamp to 2..MAX_CITIES
	always_comb begin
		if (city_count_q < 7'd2) n_eff = NW'(2);
		else if (32'(city_count_q) > 32'(MAX_CITIES)) n_eff = NW'(MAX_CITIES);
		else n_eff = NW'(32'(city_count_q));
	end

	cmr_front #(.MAX_CITIES(MAX_CITIES), .COST_BITS(COST_BITS)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.n             (n_eff),
		.cfg_clr       (cfg_wr),
		.push          (push),
		.full          (full),
		.entry_cost    (entry_cost),
		.entry_blocked (entry_blocked),
		.q_avail       (q_avail),
		.q_word        (q_word),
		.q_take        (q_take)
	);

	cmr_back #(.MAX_CITIES(MAX_CITIES), .COST_BITS(COST_BITS)) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.n               (n_eff),
		.q_avail         (q_avail),
		.q_word          (q_word),
		.q_take          (q_take),
		.pop             (pop),
		.empty           (empty),
		.reduction_total (reduction_total),
		.edge_found      (edge_found),
		.best_row        (best_row),
		.best_col        (best_col),
		.best_penalty    (best_penalty)
	);

`ifndef SYNTH
	// no zero found: position and penalty stay at zero
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !edge_found) |-> (best_row == 6'd0 && best_col == 6'd0 &&
		best_penalty == 17'd0))
		else $error("result without edge carries nonzero fields");

	// chosen edge lies inside the matrix
	a_edge_range: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && edge_found && !cfg_wr) |->
		(32'(best_row) < 32'(n_eff) && 32'(best_col) < 32'(n_eff)))
		else $error("chosen edge outside matrix");
`endif

endmodule
